// ===== src/cbt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the cubic B-spline curve tessellator.
// Depends on nothing; every other file takes names from here by scope.
package cbt_pkg;

    localparam int COORD_W = 16;
    localparam int T_FRAC  = 12;
    localparam int T_ONE   = 1 << T_FRAC;
    localparam int STEP_W  = T_FRAC + 1;
    localparam int STEP_MIN = T_ONE / 63 + 1;
    localparam int STEP_RESET = T_ONE >> 5;
    localparam int TQ_W    = STEP_W + 1;
    localparam int SQ_W    = 2 * STEP_W;
    localparam int CUBE_W  = 3 * T_FRAC + 1;
    localparam int A_W     = COORD_W + 4;
    localparam int ACC_W   = A_W + 3 * T_FRAC;
    localparam int XW      = ACC_W - (3 * T_FRAC + 1);
    localparam int RECIP_SHIFT = XW + 1;
    localparam logic [XW-1:0] RECIP =
        XW'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_SQ,
        MUL_CUBE,
        MUL_X3,
        MUL_X2,
        MUL_X1,
        MUL_Y3,
        MUL_Y2,
        MUL_Y1
    } mul_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_CUBE,
        ST_X3,
        ST_X2,
        ST_X1,
        ST_Y3,
        ST_Y2,
        ST_Y1,
        ST_INIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic    win_write;
        logic    seg_load;
        mul_op_t mul_op;
        logic    init;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic win_full;
        logic out_free;
        logic last_pt;
    } stat_t;

endpackage

// ===== src/cbt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for control points in and curve points out.
// Depends on cbt_pkg for the coordinate width.
interface cbt_pt_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cbt_pkg::COORD_W-1:0]   pt_x;
    logic signed [cbt_pkg::COORD_W-1:0]   pt_y;
    logic                                 start_curve;

    modport source (output valid, output pt_x, output pt_y, output start_curve, input ready);
    modport sink   (input valid, input pt_x, input pt_y, input start_curve, output ready);
endinterface

interface cbt_curve_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cbt_pkg::COORD_W-1:0]   curve_x;
    logic signed [cbt_pkg::COORD_W-1:0]   curve_y;
    logic                                 pen_down;
    logic                                 seg_last;

    modport source (output valid, output curve_x, output curve_y, output pen_down,
                    output seg_last, input ready);
    modport sink   (input valid, input curve_x, input curve_y, input pen_down,
                    input seg_last, output ready);
endinterface

// ===== src/cbt_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the tessellator: window fill, segment setup and point emission.
// Depends on cbt_pkg for the state, command and status types.
module cbt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           start_curve,
    output logic           in_ready,
    input  cbt_pkg::stat_t stat,
    output cbt_pkg::cmd_t  cmd
);

    cbt_pkg::state_t state_reg;
    cbt_pkg::state_t state_next;
    logic            seg_go;

    assign seg_go = in_valid && !start_curve && stat.win_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbt_pkg::ST_IDLE:
            begin
                if (seg_go)
                begin
                    state_next = cbt_pkg::ST_SQ;
                end
            end
            cbt_pkg::ST_SQ:   state_next = cbt_pkg::ST_CUBE;
            cbt_pkg::ST_CUBE: state_next = cbt_pkg::ST_X3;
            cbt_pkg::ST_X3:   state_next = cbt_pkg::ST_X2;
            cbt_pkg::ST_X2:   state_next = cbt_pkg::ST_X1;
            cbt_pkg::ST_X1:   state_next = cbt_pkg::ST_Y3;
            cbt_pkg::ST_Y3:   state_next = cbt_pkg::ST_Y2;
            cbt_pkg::ST_Y2:   state_next = cbt_pkg::ST_Y1;
            cbt_pkg::ST_Y1:   state_next = cbt_pkg::ST_INIT;
            cbt_pkg::ST_INIT: state_next = cbt_pkg::ST_EMIT;
            cbt_pkg::ST_EMIT:
            begin
                if (stat.out_free && stat.last_pt)
                begin
                    state_next = cbt_pkg::ST_IDLE;
                end
            end
            default: state_next = cbt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.win_write = 1'b0;
        cmd.seg_load  = 1'b0;
        cmd.mul_op    = cbt_pkg::MUL_NONE;
        cmd.init      = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            cbt_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.seg_load  = seg_go;
                cmd.win_write = in_valid && !seg_go;
            end
            cbt_pkg::ST_SQ:   cmd.mul_op = cbt_pkg::MUL_SQ;
            cbt_pkg::ST_CUBE: cmd.mul_op = cbt_pkg::MUL_CUBE;
            cbt_pkg::ST_X3:   cmd.mul_op = cbt_pkg::MUL_X3;
            cbt_pkg::ST_X2:   cmd.mul_op = cbt_pkg::MUL_X2;
            cbt_pkg::ST_X1:   cmd.mul_op = cbt_pkg::MUL_X1;
            cbt_pkg::ST_Y3:   cmd.mul_op = cbt_pkg::MUL_Y3;
            cbt_pkg::ST_Y2:   cmd.mul_op = cbt_pkg::MUL_Y2;
            cbt_pkg::ST_Y1:   cmd.mul_op = cbt_pkg::MUL_Y1;
            cbt_pkg::ST_INIT: cmd.init   = 1'b1;
            cbt_pkg::ST_EMIT: cmd.emit   = stat.out_free;
            default:          cmd.mul_op = cbt_pkg::MUL_NONE;
        endcase
    end

endmodule

// ===== src/cbt_dp.sv =====
`timescale 1ns / 1ps
// Datapath: point window, coefficient set-up, shared multiplier, forward
// difference engines, scaling back to coordinates and the output register.
// Depends on cbt_pkg; driven by cbt_ctrl through cmd_t and stat_t.
module cbt_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cbt_pkg::cmd_t                       cmd,
    output cbt_pkg::stat_t                      stat,
    input  logic                                cfg_we,
    input  logic [cbt_pkg::STEP_W-1:0]          cfg_wdata,
    input  logic signed [cbt_pkg::COORD_W-1:0]  pt_x,
    input  logic signed [cbt_pkg::COORD_W-1:0]  pt_y,
    input  logic                                start_curve,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [cbt_pkg::COORD_W-1:0]  curve_x,
    output logic signed [cbt_pkg::COORD_W-1:0]  curve_y,
    output logic                                pen_down,
    output logic                                seg_last
);

    localparam int CW = cbt_pkg::COORD_W;
    localparam int AW = cbt_pkg::A_W;
    localparam int DW = cbt_pkg::ACC_W;
    localparam int TF = cbt_pkg::T_FRAC;
    localparam int XW = cbt_pkg::XW;

    function automatic logic signed [CW-1:0] to_coord(input logic signed [DW-1:0] f);
        logic signed [XW-1:0]  fs;
        logic                  nz;
        logic [XW-1:0]         mag;
        logic [2*XW-1:0]       prod;
        logic [CW:0]           q;
        logic [CW:0]           qs;
        fs   = f[DW-1 -: XW];
        nz   = |f[3*TF:0];
        mag  = f[DW-1] ? (-fs - XW'(nz)) : fs;
        prod = mag * cbt_pkg::RECIP;
        q    = prod[cbt_pkg::RECIP_SHIFT +: CW+1];
        qs   = f[DW-1] ? -q : q;
        return qs[CW-1:0];
    endfunction

    logic signed [CW-1:0]           win_x_reg [3];
    logic signed [CW-1:0]           win_y_reg [3];
    logic [1:0]                     held_reg;
    logic [1:0]                     win_idx;
    logic signed [CW-1:0]           p3x_reg;
    logic signed [CW-1:0]           p3y_reg;
    logic [cbt_pkg::STEP_W-1:0]     step_reg;
    logic [cbt_pkg::STEP_W-1:0]     step;

    logic signed [AW-1:0]           e0x, e1x, e2x, e3x, e0y, e1y, e2y, e3y;
    logic signed [AW-1:0]           a3x_reg, a2x_reg, a1x_reg, a0x_reg;
    logic signed [AW-1:0]           a3y_reg, a2y_reg, a1y_reg, a0y_reg;

    logic [cbt_pkg::SQ_W-1:0]       s2_reg;
    logic [cbt_pkg::CUBE_W-1:0]     s3_reg;
    logic signed [DW-1:0]           m3x_reg, m2x_reg, m1x_reg, m3y_reg, m2y_reg, m1y_reg;

    logic signed [AW-1:0]           mul_a;
    logic [cbt_pkg::CUBE_W-1:0]     mul_b;
    logic signed [AW+cbt_pkg::CUBE_W:0] mul_p;
    logic signed [DW-1:0]           prod;

    logic signed [DW-1:0]           fx_reg, d1x_reg, d2x_reg, d3x_reg;
    logic signed [DW-1:0]           fy_reg, d1y_reg, d2y_reg, d3y_reg;
    logic signed [DW-1:0]           d3x_init, d3y_init;
    logic [cbt_pkg::TQ_W-1:0]       tq_reg;

    logic                           out_valid_reg;
    logic signed [CW-1:0]           curve_x_reg, curve_y_reg;
    logic                           pen_down_reg, seg_last_reg;

    assign step = (step_reg < cbt_pkg::STEP_W'(cbt_pkg::STEP_MIN))
                ? cbt_pkg::STEP_W'(cbt_pkg::STEP_MIN) : step_reg;

    assign win_idx = start_curve ? 2'd0 : held_reg;

    assign stat.win_full = (held_reg == 2'd3);
    assign stat.out_free = !out_valid_reg || out_ready;
    assign stat.last_pt  = ({1'b0, tq_reg} + (cbt_pkg::TQ_W+1)'(step))
                         > (cbt_pkg::TQ_W+1)'(cbt_pkg::T_ONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= cbt_pkg::STEP_W'(cbt_pkg::STEP_RESET);
            held_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
            if (cmd.win_write)
            begin
                held_reg <= win_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.win_write)
            begin
                win_x_reg[win_idx] <= pt_x;
                win_y_reg[win_idx] <= pt_y;
            end
            else if (cmd.emit && stat.last_pt)
            begin
                win_x_reg[0] <= win_x_reg[1];
                win_x_reg[1] <= win_x_reg[2];
                win_x_reg[2] <= p3x_reg;
                win_y_reg[0] <= win_y_reg[1];
                win_y_reg[1] <= win_y_reg[2];
                win_y_reg[2] <= p3y_reg;
            end
        end
    end

    assign e0x = AW'(win_x_reg[0]);
    assign e1x = AW'(win_x_reg[1]);
    assign e2x = AW'(win_x_reg[2]);
    assign e3x = AW'(pt_x);
    assign e0y = AW'(win_y_reg[0]);
    assign e1y = AW'(win_y_reg[1]);
    assign e2y = AW'(win_y_reg[2]);
    assign e3y = AW'(pt_y);

    always_ff @(posedge clk)
    begin
        if (cmd.seg_load)
        begin
            p3x_reg <= pt_x;
            p3y_reg <= pt_y;
            a3x_reg <= e3x - e0x + (e1x <<< 1) + e1x - (e2x <<< 1) - e2x;
            a2x_reg <= (e0x <<< 1) + e0x - (e1x <<< 2) - (e1x <<< 1) + (e2x <<< 1) + e2x;
            a1x_reg <= ((e2x - e0x) <<< 1) + (e2x - e0x);
            a0x_reg <= e0x + (e1x <<< 2) + e2x;
            a3y_reg <= e3y - e0y + (e1y <<< 1) + e1y - (e2y <<< 1) - e2y;
            a2y_reg <= (e0y <<< 1) + e0y - (e1y <<< 2) - (e1y <<< 1) + (e2y <<< 1) + e2y;
            a1y_reg <= ((e2y - e0y) <<< 1) + (e2y - e0y);
            a0y_reg <= e0y + (e1y <<< 2) + e2y;
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            cbt_pkg::MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            cbt_pkg::MUL_SQ:
            begin
                mul_a = AW'(step);
                mul_b = cbt_pkg::CUBE_W'(step);
            end
            cbt_pkg::MUL_CUBE:
            begin
                mul_a = AW'(step);
                mul_b = cbt_pkg::CUBE_W'(s2_reg);
            end
            cbt_pkg::MUL_X3:
            begin
                mul_a = a3x_reg;
                mul_b = s3_reg;
            end
            cbt_pkg::MUL_X2:
            begin
                mul_a = a2x_reg;
                mul_b = cbt_pkg::CUBE_W'(s2_reg);
            end
            cbt_pkg::MUL_X1:
            begin
                mul_a = a1x_reg;
                mul_b = cbt_pkg::CUBE_W'(step);
            end
            cbt_pkg::MUL_Y3:
            begin
                mul_a = a3y_reg;
                mul_b = s3_reg;
            end
            cbt_pkg::MUL_Y2:
            begin
                mul_a = a2y_reg;
                mul_b = cbt_pkg::CUBE_W'(s2_reg);
            end
            cbt_pkg::MUL_Y1:
            begin
                mul_a = a1y_reg;
                mul_b = cbt_pkg::CUBE_W'(step);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});
    assign prod  = mul_p[DW-1:0];

    always_ff @(posedge clk)
    begin
        unique case (cmd.mul_op)
            cbt_pkg::MUL_SQ:   s2_reg  <= prod[cbt_pkg::SQ_W-1:0];
            cbt_pkg::MUL_CUBE: s3_reg  <= prod[cbt_pkg::CUBE_W-1:0];
            cbt_pkg::MUL_X3:   m3x_reg <= prod;
            cbt_pkg::MUL_X2:   m2x_reg <= prod;
            cbt_pkg::MUL_X1:   m1x_reg <= prod;
            cbt_pkg::MUL_Y3:   m3y_reg <= prod;
            cbt_pkg::MUL_Y2:   m2y_reg <= prod;
            cbt_pkg::MUL_Y1:   m1y_reg <= prod;
            default:           s2_reg  <= s2_reg;
        endcase
    end

    assign d3x_init = (m3x_reg <<< 2) + (m3x_reg <<< 1);
    assign d3y_init = (m3y_reg <<< 2) + (m3y_reg <<< 1);

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            fx_reg  <= {a0x_reg, (3*TF)'(0)};
            d1x_reg <= m3x_reg + (m2x_reg <<< TF) + (m1x_reg <<< (2*TF));
            d2x_reg <= d3x_init + (m2x_reg <<< (TF+1));
            d3x_reg <= d3x_init;
            fy_reg  <= {a0y_reg, (3*TF)'(0)};
            d1y_reg <= m3y_reg + (m2y_reg <<< TF) + (m1y_reg <<< (2*TF));
            d2y_reg <= d3y_init + (m2y_reg <<< (TF+1));
            d3y_reg <= d3y_init;
            tq_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            fx_reg  <= fx_reg + d1x_reg;
            d1x_reg <= d1x_reg + d2x_reg;
            d2x_reg <= d2x_reg + d3x_reg;
            fy_reg  <= fy_reg + d1y_reg;
            d1y_reg <= d1y_reg + d2y_reg;
            d2y_reg <= d2y_reg + d3y_reg;
            tq_reg  <= tq_reg + cbt_pkg::TQ_W'(step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            curve_x_reg  <= to_coord(fx_reg);
            curve_y_reg  <= to_coord(fy_reg);
            pen_down_reg <= (tq_reg != '0);
            seg_last_reg <= stat.last_pt;
        end
    end

    assign out_valid = out_valid_reg;
    assign curve_x   = curve_x_reg;
    assign curve_y   = curve_y_reg;
    assign pen_down  = pen_down_reg;
    assign seg_last  = seg_last_reg;

endmodule

// ===== src/cubic_bspline_curve_tessellator.sv =====
`timescale 1ns / 1ps
// Uniform cubic B-spline tessellator. Control points enter on in_ch; the first
// three of a curve only fill the window. Every later point completes a segment.
// Set-up runs one shared multiplier for the step powers, then three coefficient
// products per axis, and then loads the difference engines. The curve points
// then leave on out_ch at one per cycle while out_ch does not hold back a
// waiting point, by forward differencing: floor(4096 / step) + 1 points for a
// step of at most one, else a single point. A step below 66 counts as 66, so a
// segment gives at most 63 points. The next control point is taken as soon as
// the last point of a segment sits in the output register. t_step may be
// rewritten only while the block is idle.
// Depends on cbt_pkg, cbt_if, cbt_ctrl and cbt_dp.
module cubic_bspline_curve_tessellator (
    input  logic                          clk,
    input  logic                          rst_n,
    cbt_pt_if.sink                        in_ch,
    cbt_curve_if.source                   out_ch,
    input  logic                          cfg_we,
    input  logic [cbt_pkg::STEP_W-1:0]    cfg_wdata
);

    cbt_pkg::cmd_t  cmd;
    cbt_pkg::stat_t stat;

    cbt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .start_curve (in_ch.start_curve),
        .in_ready    (in_ch.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    cbt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pt_x        (in_ch.pt_x),
        .pt_y        (in_ch.pt_y),
        .start_curve (in_ch.start_curve),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .curve_x     (out_ch.curve_x),
        .curve_y     (out_ch.curve_y),
        .pen_down    (out_ch.pen_down),
        .seg_last    (out_ch.seg_last)
    );

endmodule

// ===== dv/cubic_bspline_curve_tessellator_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the cubic B-spline tessellator: random and directed control points,
// an exact integer predictor of every curve point, and random stalls on both channels.
// Depends on cbt_pkg, cbt_if and the tessellator RTL.
module cubic_bspline_curve_tessellator_test;
    import cbt_pkg::*;

    localparam int     SEG_PTS_MAX    = 64;
    localparam int     SETTLE_CYCLES  = 80;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     REPORT_LIMIT   = 10;
    localparam longint COORD_BIAS     = longint'(1) << (COORD_W - 1);
    localparam longint SEG_DEN        = longint'(6) << (3 * T_FRAC);
    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      start_curve;
        logic                      hold;
    } ctrl_pt_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      pen_down;
        logic                      seg_last;
    } curve_pt_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    cbt_pt_if    pt_if();
    cbt_curve_if curve_if();

    cubic_bspline_curve_tessellator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (pt_if),
        .out_ch    (curve_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic [STEP_W-1:0]         step_cfg;
    logic signed [COORD_W-1:0] win_x [3];
    logic signed [COORD_W-1:0] win_y [3];
    int unsigned               held;

    ctrl_pt_t    point_feed [$];
    curve_pt_t   due_points [$];
    ctrl_pt_t    cur_pt;
    bit          pt_presenting;
    int unsigned pt_gap;
    bit          pt_calm;
    int unsigned curve_stall;
    bit          curve_calm;
    int unsigned quiet_cycles;
    int unsigned mismatches;

    function automatic int unsigned draw_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic signed [COORD_W-1:0] axis_value(
        input longint c0, input longint c1, input longint c2, input longint c3,
        input longint w0, input longint w1, input longint w2, input longint w3);
        longint acc;
        longint q;
        longint v;
        acc = (c0 + COORD_BIAS) * w0 + (c1 + COORD_BIAS) * w1
            + (c2 + COORD_BIAS) * w2 + (c3 + COORD_BIAS) * w3;
        q = acc / SEG_DEN;
        v = q - COORD_BIAS;
        if ((acc % SEG_DEN) != 0 && v < 0)
            v = v + 1;
        return v[COORD_W-1:0];
    endfunction

    function automatic void tessellate_segment(input logic signed [COORD_W-1:0] nx,
                                               input logic signed [COORD_W-1:0] ny);
        longint    stp;
        longint    tq;
        longint    t2;
        longint    t3;
        longint    u;
        longint    s;
        longint    s3;
        longint    w0;
        longint    w1;
        longint    w2;
        longint    w3;
        int        n;
        curve_pt_t pt;
        s   = T_ONE;
        s3  = s * s * s;
        stp = (step_cfg < STEP_MIN) ? STEP_MIN : step_cfg;
        n   = 0;
        for (tq = 0; tq <= T_ONE && n < SEG_PTS_MAX; tq = tq + stp)
        begin
            t2 = tq * tq;
            t3 = t2 * tq;
            u  = s - tq;
            w0 = u * u * u;
            w1 = 3 * t3 - 6 * t2 * s + 4 * s3;
            w2 = 3 * t2 * s + 3 * tq * s * s + s3 - 3 * t3;
            w3 = t3;
            pt.x = axis_value(win_x[0], win_x[1], win_x[2], nx, w0, w1, w2, w3);
            pt.y = axis_value(win_y[0], win_y[1], win_y[2], ny, w0, w1, w2, w3);
            pt.pen_down = (tq != 0);
            pt.seg_last = (tq + stp > T_ONE) || (n + 1 == SEG_PTS_MAX);
            due_points.push_back(pt);
            n = n + 1;
        end
    endfunction

    function automatic void advance_window(input ctrl_pt_t p);
        if (p.start_curve)
            held = 0;
        if (held < 3)
        begin
            win_x[held] = p.x;
            win_y[held] = p.y;
            held = held + 1;
        end
        else
        begin
            tessellate_segment(p.x, p.y);
            win_x[0] = win_x[1];
            win_x[1] = win_x[2];
            win_x[2] = p.x;
            win_y[0] = win_y[1];
            win_y[1] = win_y[2];
            win_y[2] = p.y;
        end
    endfunction

    function automatic void check_curve_point();
        curve_pt_t got;
        curve_pt_t want;
        got.x        = curve_if.curve_x;
        got.y        = curve_if.curve_y;
        got.pen_down = curve_if.pen_down;
        got.seg_last = curve_if.seg_last;
        if (due_points.size() == 0)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_LIMIT)
                $display("unexpected curve point x=%0d y=%0d pen_down=%0b seg_last=%0b",
                         got.x, got.y, got.pen_down, got.seg_last);
        end
        else
        begin
            want = due_points.pop_front();
            if (got !== want)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= REPORT_LIMIT)
                    $display({"curve point mismatch: expected x=%0d y=%0d pen_down=%0b ",
                              "seg_last=%0b, got x=%0d y=%0d pen_down=%0b seg_last=%0b"},
                             want.x, want.y, want.pen_down, want.seg_last,
                             got.x, got.y, got.pen_down, got.seg_last);
            end
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_presenting = 1'b0;
            pt_gap = 0;
            pt_if.valid <= 1'b0;
            pt_if.pt_x <= '0;
            pt_if.pt_y <= '0;
            pt_if.start_curve <= 1'b0;
        end
        else
        begin
            if (pt_if.valid && pt_if.ready)
            begin
                advance_window(cur_pt);
                pt_presenting = 1'b0;
                pt_gap = draw_gap(pt_calm);
                if ($urandom_range(0, 15) == 0)
                    pt_calm = !pt_calm;
            end
            if (!pt_presenting)
            begin
                if (pt_gap > 0)
                    pt_gap = pt_gap - 1;
                else if (point_feed.size() > 0 &&
                         !(point_feed[0].hold && due_points.size() > 0))
                begin
                    cur_pt = point_feed.pop_front();
                    pt_presenting = 1'b1;
                end
            end
            pt_if.valid <= pt_presenting;
            pt_if.pt_x <= cur_pt.x;
            pt_if.pt_y <= cur_pt.y;
            pt_if.start_curve <= cur_pt.start_curve;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_stall = 0;
            curve_if.ready <= 1'b0;
        end
        else
        begin
            if (curve_if.valid && curve_if.ready)
            begin
                check_curve_point();
                curve_stall = draw_gap(curve_calm);
                if ($urandom_range(0, 31) == 0)
                    curve_calm = !curve_calm;
            end
            else if (curve_stall > 0)
                curve_stall = curve_stall - 1;
            curve_if.ready <= (curve_stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pt_if.valid && pt_if.ready) || (curve_if.valid && curve_if.ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic [15:0] r;
        r = 16'($urandom());
        case ($urandom_range(0, 5))
            0: return r[0] ? C_MAX : C_MIN;
            1: return COORD_W'(int'($urandom_range(0, 16)) - 8);
            default: return r[COORD_W-1:0];
        endcase
    endfunction

    function automatic void queue_point(input int x, input int y,
                                        input bit start, input bit hold);
        ctrl_pt_t p;
        p.x = COORD_W'(x);
        p.y = COORD_W'(y);
        p.start_curve = start;
        p.hold = hold;
        point_feed.push_back(p);
    endfunction

    function automatic void queue_curve(input int unsigned len, input bit hold_first);
        for (int unsigned i = 0; i < len; i++)
            queue_point(pick_coord(), pick_coord(), i == 0, hold_first && i == 0);
    endfunction

    function automatic void queue_random_points(input int unsigned count);
        int unsigned made;
        int unsigned len;
        made = 0;
        while (made < count)
        begin
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = $urandom_range(1, 3);
                default: len = $urandom_range(4, 9);
            endcase
            if (len == 1)
                queue_point(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)), 1'b0);
            else
                queue_curve(len, len > 3 && $urandom_range(0, 7) == 0);
            made = made + len;
        end
    endfunction

    task automatic settle();
        while (point_feed.size() != 0 || pt_presenting || due_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_cfg = v;
    endtask

    logic [STEP_W-1:0] step_plan [$];

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pt_if.valid = 1'b0;
        pt_if.pt_x = '0;
        pt_if.pt_y = '0;
        pt_if.start_curve = 1'b0;
        curve_if.ready = 1'b0;
        step_cfg = STEP_W'(STEP_RESET);
        held = 0;
        for (int i = 0; i < 3; i++)
        begin
            win_x[i] = '0;
            win_y[i] = '0;
        end
        pt_presenting = 1'b0;
        pt_gap = 0;
        pt_calm = 1'b0;
        curve_stall = 0;
        curve_calm = 1'b0;
        quiet_cycles = 0;
        mismatches = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // extremes, restarts on a full window, flat curves, truncation near zero
        queue_point(C_MIN, C_MAX, 1, 0);
        queue_point(C_MAX, C_MIN, 0, 0);
        queue_point(C_MIN, C_MIN, 0, 0);
        queue_point(C_MAX, C_MAX, 0, 0);
        queue_point(0, 0, 0, 0);
        queue_point(-1, 1, 0, 0);
        for (int i = 0; i < 4; i++)
            queue_point(C_MIN, C_MIN, i == 0, 0);
        queue_point(C_MAX, C_MAX, 0, 0);
        queue_point(5, -5, 1, 0);
        queue_point(7, -7, 1, 0);
        queue_point(1, -1, 1, 0);
        queue_point(-1, -1, 0, 0);
        queue_point(-2, 2, 0, 0);
        queue_point(3, -3, 0, 0);
        for (int i = 0; i < 4; i++)
            queue_point(C_MAX, C_MAX, i == 0, i == 0);
        queue_point(-7, 11, 0, 0);
        settle();

        step_plan = '{13'd0, 13'd65, 13'd4096, 13'd4097, 13'd8191, 13'd66};
        step_plan.push_back(STEP_W'($urandom_range(65, 4096)));
        step_plan.push_back(STEP_W'($urandom_range(65, 4096)));
        foreach (step_plan[i])
        begin
            write_step(step_plan[i]);
            queue_random_points(21);
            settle();
        end

        if (mismatches == 0 && due_points.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
src/cbt_pkg.sv
src/cbt_if.sv
src/cbt_ctrl.sv
src/cbt_dp.sv
src/cubic_bspline_curve_tessellator.sv
dv/cubic_bspline_curve_tessellator_test.sv
